[hw/rtl/midi_note_gate_trigger_macros.svh]
// Assertion macros for the MIDI note gate trigger block.
`ifndef MIDI_NOTE_GATE_TRIGGER_MACROS_SVH
`define MIDI_NOTE_GATE_TRIGGER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MNG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MNG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mng_pkg.sv]
// Shared types, constants and helpers of the MIDI note gate trigger block.
`default_nettype none

package mng_pkg;

    localparam int CHANNELS   = 16;
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int HOLD_W     = 16;
    localparam int CH_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDX_W-1:0]  IDX_LAST        = IDX_W'(CHANNELS - 1);
    localparam logic [HOLD_W-1:0] HOLD_RESET      = 16'd48;
    localparam logic [VEL_W-1:0]  LEVEL_FULL      = 7'd127;
    localparam logic [VEL_W-1:0]  LEVEL_OFF       = 7'd0;
    localparam logic [3:0]        STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0]        STATUS_NOTE_ON  = 4'h9;

    typedef enum logic [1:0] {
        FUNC_TICK,
        FUNC_MSG,
        FUNC_LEARN,
        FUNC_PANIC
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VEL_MODE,
        CFG_HOLD_TICKS
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TICK
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PRESS,
        OP_RELEASE,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_func       func;
        logic [3:0]  status;
        logic [6:0]  note;
        logic [6:0]  value;
        logic [3:0]  slot;
    } t_mng_in;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [VEL_W-1:0] level;
        logic             last;
    } t_mng_out;

    // One step of the channel unit, issued by the sequencer.
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              learn_we;
        logic [IDX_W-1:0]  learn_idx;
        logic [NOTE_W-1:0] learn_note;
        logic              panic;
    } t_mng_cmd;

    // Pad grid: bottom row starts at note 36, rows of four.
    function automatic logic [NOTE_W-1:0] init_note(input int i);
        int row;
        int col;
        row = i >> 2;
        col = i & 3;
        return NOTE_W'((48 - 4 * row + col) & 127);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/midi_note_gate_trigger.sv]
// Top level of the MIDI note gate trigger: config registers, output register, assertions.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------------
//   input    | in        | i_in_valid / o_in_stall   | i_in_data  (t_mng_in)
//   output   | out       | o_out_valid / i_out_stall | o_out_data (t_mng_out)
//   config   | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A tick is accepted, then the shared channel unit gives one channel result per cycle,
// holding while the output register is stalled. A note on or note off is accepted, then
// scanned with one channel compare per cycle. Arm, panic and ignored statuses complete
// at accept. A tick's last result may still wait in the output register while the next
// item is taken.
// Synchronous active-low reset clears gates, hold counts and learn state, loads the pad grid.
`default_nettype none

`include "midi_note_gate_trigger_macros.svh"

module midi_note_gate_trigger import mng_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire t_mng_in               i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_mng_out                   o_out_data,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_vel_mode;
    logic [HOLD_W-1:0] r_hold_ticks;
    logic              r_out_valid;
    t_mng_out          r_out_data;

    t_mng_cmd          w_cmd;
    logic [VEL_W-1:0]  w_level;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    mng_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd)
    );

    mng_chan u_chan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_vel_mode   (r_vel_mode),
        .i_hold_ticks (r_hold_ticks),
        .o_level      (w_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_mode   <= 1'b0;
            r_hold_ticks <= HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_VEL_MODE:   r_vel_mode   <= i_cfg_data[0];
                CFG_HOLD_TICKS: r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.op == OP_TICK) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.op == OP_TICK) begin
            r_out_data.channel <= CH_W'(w_cmd.idx);
            r_out_data.level   <= w_level;
            r_out_data.last    <= (w_cmd.idx == IDX_LAST);
        end
    end

    // a tick is still in flight while a result other than the last is pending
    `MNG_ASSERT_NOW(a_mid_tick_busy, o_out_valid && !o_out_data.last, o_in_stall,
        "non-final channel result pending while input side is idle")
    `MNG_ASSERT_NEXT(a_tick_starts_scan,
        i_in_valid && !o_in_stall && (i_in_data.func == FUNC_TICK), o_in_stall,
        "accepted tick did not start the channel scan")
    `MNG_ASSERT_NEXT(a_panic_one_cycle,
        i_in_valid && !o_in_stall && (i_in_data.func == FUNC_PANIC), !o_in_stall,
        "panic did not complete in one cycle")

endmodule

`default_nettype wire

[hw/rtl/mng_seq.sv]
// Sequencer: takes items, tracks learn arming, steps the channel index.
`default_nettype none

module mng_seq import mng_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_mng_in  i_in_data,
    output logic          o_in_stall,
    input  wire logic     i_out_free,
    output t_mng_cmd      o_cmd
);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    t_op                r_op;
    logic [NOTE_W-1:0]  r_note;
    logic [VEL_W-1:0]   r_vel;
    logic               r_pend;
    logic [3:0]         r_target;

    logic w_accept;
    logic w_press;
    logic w_release;
    logic w_step;
    logic w_end;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_press   = (i_in_data.status == STATUS_NOTE_ON) && (i_in_data.value != 7'd0);
    assign w_release = (i_in_data.status == STATUS_NOTE_OFF) ||
                       ((i_in_data.status == STATUS_NOTE_ON) && (i_in_data.value == 7'd0));
    assign w_step    = (r_state == S_SCAN) || ((r_state == S_TICK) && i_out_free);
    assign w_end     = (r_idx == IDX_LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.func)
                        FUNC_TICK:  n_state = S_TICK;
                        FUNC_MSG:   if (w_press || w_release) n_state = S_SCAN;
                        FUNC_LEARN: n_state = S_IDLE;
                        FUNC_PANIC: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN:  if (w_end) n_state = S_IDLE;
            S_TICK:  if (i_out_free && w_end) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != S_IDLE);
        o_cmd.op         = OP_NONE;
        if (r_state == S_SCAN) o_cmd.op = r_op;
        else if ((r_state == S_TICK) && i_out_free) o_cmd.op = OP_TICK;
        o_cmd.idx        = r_idx;
        o_cmd.note       = r_note;
        o_cmd.vel        = r_vel;
        // learned note is written at accept so the scan already sees it
        o_cmd.learn_we   = w_accept && (i_in_data.func == FUNC_MSG) && w_press && r_pend &&
                           (int'(r_target) < CHANNELS);
        o_cmd.learn_idx  = IDX_W'(r_target);
        o_cmd.learn_note = i_in_data.note;
        o_cmd.panic      = w_accept && (i_in_data.func == FUNC_PANIC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_op     <= OP_NONE;
            r_pend   <= 1'b0;
            r_target <= '0;
        end else begin
            r_state <= n_state;
            if (w_step) r_idx <= w_end ? '0 : r_idx + IDX_W'(1);
            if (w_accept) begin
                unique case (i_in_data.func)
                    FUNC_MSG: begin
                        r_op <= w_press ? OP_PRESS : OP_RELEASE;
                        if (w_press) r_pend <= 1'b0;
                    end
                    FUNC_LEARN: begin
                        r_pend   <= 1'b1;
                        r_target <= i_in_data.slot;
                    end
                    FUNC_TICK, FUNC_PANIC: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_note <= i_in_data.note;
            r_vel  <= i_in_data.value;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mng_chan.sv]
// Channel state and the shared note compare / hold decrement unit.
`default_nettype none

module mng_chan import mng_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mng_cmd          i_cmd,
    input  wire logic              i_vel_mode,
    input  wire logic [HOLD_W-1:0] i_hold_ticks,
    output logic [VEL_W-1:0]       o_level
);

    logic              r_gate [CHANNELS];
    logic [HOLD_W-1:0] r_hold [CHANNELS];
    logic [VEL_W-1:0]  r_vel  [CHANNELS];
    logic [NOTE_W-1:0] r_note [CHANNELS];

    logic              w_match;
    logic              w_hold_nz;
    logic [HOLD_W-1:0] w_hold_dec;

    assign w_match    = (r_note[i_cmd.idx] == i_cmd.note);
    assign w_hold_nz  = (r_hold[i_cmd.idx] != '0);
    assign w_hold_dec = r_hold[i_cmd.idx] - HOLD_W'(1);
    assign o_level    = w_hold_nz ? (i_vel_mode ? r_vel[i_cmd.idx] : LEVEL_FULL) : LEVEL_OFF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_gate[i] <= 1'b0;
                r_hold[i] <= '0;
            end
        end else if (i_cmd.panic) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_gate[i] <= 1'b0;
                r_hold[i] <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_PRESS: begin
                    if (w_match) begin
                        r_gate[i_cmd.idx] <= 1'b1;
                        r_hold[i_cmd.idx] <= i_hold_ticks;
                    end
                end
                OP_RELEASE: if (w_match) r_gate[i_cmd.idx] <= 1'b0;
                // released channel keeps its pulse until the hold runs out
                OP_TICK: if (w_hold_nz && !r_gate[i_cmd.idx]) r_hold[i_cmd.idx] <= w_hold_dec;
                OP_NONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_PRESS) && w_match) r_vel[i_cmd.idx] <= i_cmd.vel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) r_note[i] <= init_note(i);
        end else if (i_cmd.learn_we) begin
            r_note[i_cmd.learn_idx] <= i_cmd.learn_note;
        end
    end

endmodule

`default_nettype wire

[tb/sv/midi_note_gate_trigger_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the MIDI note gate trigger: directed and random traffic against a level predictor.

module midi_note_gate_trigger_tb;
    import mng_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_mng_in               in_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_mng_out              out_data;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    midi_note_gate_trigger dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predicted channel state and register copies
    logic            chan_gate [CHANNELS];
    logic [15:0]     hold_left [CHANNELS];
    logic [6:0]      vel_store [CHANNELS];
    logic [6:0]      pad_note  [CHANNELS];
    logic            learn_armed;
    logic [3:0]      learn_slot;
    logic            vel_mode_copy;
    logic [15:0]     hold_copy;

    t_mng_in  msg_backlog [$];
    t_mng_out levels_due  [$];
    int       items_queued = 0;
    int       items_taken = 0;
    int       fault_count = 0;
    bit       calm = 1'b0;
    int       in_gap = 0;
    int       stall_left = 0;

    task automatic gate_notes(input logic [6:0] note, input logic [6:0] vel, input bit on);
        int ch;
        for (ch = 0; ch < CHANNELS; ch++) begin
            if (pad_note[ch] == note) begin
                chan_gate[ch] = on;
                if (on) begin
                    hold_left[ch] = hold_copy;
                    vel_store[ch] = vel;
                end
            end
        end
    endtask

    task automatic predict_levels(input t_mng_in it);
        int       ch;
        t_mng_out r;
        case (it.func)
            FUNC_TICK: begin
                for (ch = 0; ch < CHANNELS; ch++) begin
                    r.channel = 4'(ch);
                    r.level   = LEVEL_OFF;
                    r.last    = (ch == CHANNELS - 1);
                    if (hold_left[ch] != 0) begin
                        r.level = vel_mode_copy ? vel_store[ch] : LEVEL_FULL;
                        if (!chan_gate[ch])
                            hold_left[ch]--;
                    end
                    levels_due.push_back(r);
                end
            end
            FUNC_MSG: begin
                if (it.status == STATUS_NOTE_ON && it.value != 0) begin
                    // learn first, so the learning channel fires on this press
                    if (learn_armed) begin
                        if (learn_slot < CHANNELS)
                            pad_note[learn_slot] = it.note;
                        learn_armed = 1'b0;
                    end
                    gate_notes(it.note, it.value, 1'b1);
                end else if (it.status == STATUS_NOTE_ON || it.status == STATUS_NOTE_OFF) begin
                    gate_notes(it.note, it.value, 1'b0);
                end
            end
            FUNC_LEARN: begin
                learn_armed = 1'b1;
                learn_slot  = it.slot;
            end
            default: begin
                for (ch = 0; ch < CHANNELS; ch++) begin
                    chan_gate[ch] = 1'b0;
                    hold_left[ch] = '0;
                end
            end
        endcase
    endtask

    function automatic t_mng_in mk(input t_func f, input logic [3:0] st, input logic [6:0] n,
                                   input logic [6:0] v, input logic [3:0] s);
        t_mng_in it;
        it.func   = f;
        it.status = st;
        it.note   = n;
        it.value  = v;
        it.slot   = s;
        return it;
    endfunction

    function automatic t_mng_in rand_item();
        t_mng_in it;
        int      pick;
        it.status = 4'($urandom_range(0, 15));
        it.note   = 7'($urandom_range(0, 127));
        it.value  = 7'($urandom_range(0, 127));
        it.slot   = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.func = FUNC_TICK;
        end else if (pick < 82) begin
            it.func = FUNC_MSG;
            // mostly notes some channel listens to
            if ($urandom_range(0, 9) < 7)
                it.note = pad_note[$urandom_range(0, CHANNELS - 1)];
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                it.status = STATUS_NOTE_ON;
                it.value  = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
            end else if (pick < 8) begin
                it.status = STATUS_NOTE_OFF;
            end
        end else if (pick < 94) begin
            it.func = FUNC_LEARN;
        end else begin
            it.func = FUNC_PANIC;
        end
        return it;
    endfunction

    task automatic queue_item(input t_mng_in it);
        msg_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            queue_item(rand_item());
            // small chunks keep the note choice close to the learned notes
            if (i % 10 == 9)
                while (msg_backlog.size() != 0) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || levels_due.size() != 0) @(posedge clk);
        // a message gives no result but keeps the block busy for a channel scan
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_VEL_MODE)
            vel_mode_copy = data[0];
        else
            hold_copy = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_levels(in_data);
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (msg_backlog.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= msg_backlog.pop_front();
                    if (!calm && $urandom_range(0, 4) == 0)
                        in_gap = $urandom_range(1, 6);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and stall generator
    always @(posedge clk) begin : mon
        t_mng_out want;
        bit       bad;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (levels_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result: channel %0d level %0d last %0b",
                                 out_data.channel, out_data.level, out_data.last);
                end else begin
                    want = levels_due.pop_front();
                    bad  = 1'b0;
                    if (out_data.channel !== want.channel) bad = 1'b1;
                    if (out_data.level !== want.level) bad = 1'b1;
                    if (out_data.last !== want.last) bad = 1'b1;
                    if (bad) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch at %0t: channel %0d/%0d level %0d/%0d last %0b/%0b",
                                     $realtime, want.channel, out_data.channel, want.level,
                                     out_data.level, want.last, out_data.last);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stim
        int ch;
        for (ch = 0; ch < CHANNELS; ch++) begin
            chan_gate[ch] = 1'b0;
            hold_left[ch] = '0;
            vel_store[ch] = '0;
            pad_note[ch]  = 7'(48 - 4 * (ch / 4) + ch % 4);
        end
        learn_armed   = 1'b0;
        learn_slot    = '0;
        vel_mode_copy = 1'b0;
        hold_copy     = HOLD_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset register values
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_MSG, STATUS_NOTE_ON, 7'd36, 7'd127, 4'd0));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_MSG, STATUS_NOTE_ON, 7'd51, 7'd1, 4'd0));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_MSG, STATUS_NOTE_OFF, 7'd36, 7'd0, 4'd0));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_MSG, STATUS_NOTE_ON, 7'd51, 7'd0, 4'd0));  // note on, zero velocity
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_MSG, 4'hA, 7'd48, 7'd100, 4'd0));          // ignored statuses
        queue_item(mk(FUNC_MSG, 4'h0, 7'd127, 7'd127, 4'd15));
        queue_item(mk(FUNC_LEARN, 4'h0, 7'd0, 7'd0, 4'd15));
        queue_item(mk(FUNC_MSG, STATUS_NOTE_ON, 7'd127, 7'd64, 4'd0));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_LEARN, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_LEARN, 4'h0, 7'd0, 7'd0, 4'd5));          // re-arm moves the target
        queue_item(mk(FUNC_MSG, STATUS_NOTE_ON, 7'd0, 7'd127, 4'd0));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_LEARN, 4'h0, 7'd0, 7'd0, 4'd7));
        queue_item(mk(FUNC_PANIC, 4'h0, 7'd0, 7'd0, 4'd0));          // learn survives panic
        queue_item(mk(FUNC_MSG, STATUS_NOTE_ON, 7'd100, 7'd9, 4'd0));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        queue_item(mk(FUNC_TICK, 4'hF, 7'd127, 7'd127, 4'd15));
        queue_item(mk(FUNC_PANIC, 4'hF, 7'd127, 7'd127, 4'd15));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        wait_drained();

        write_reg(CFG_VEL_MODE, 16'd1);
        write_reg(CFG_HOLD_TICKS, 16'd3);
        run_random(120);
        wait_drained();

        write_reg(CFG_VEL_MODE, 16'd0);
        write_reg(CFG_HOLD_TICKS, 16'd1);
        run_random(100);
        wait_drained();

        write_reg(CFG_VEL_MODE, 16'd1);
        write_reg(CFG_HOLD_TICKS, 16'hFFFF);
        run_random(60);
        wait_drained();

        // zero hold: presses never produce a pulse
        write_reg(CFG_HOLD_TICKS, 16'd0);
        queue_item(mk(FUNC_MSG, STATUS_NOTE_ON, 7'd48, 7'd50, 4'd0));
        queue_item(mk(FUNC_TICK, 4'h0, 7'd0, 7'd0, 4'd0));
        run_random(30);
        wait_drained();

        calm = 1'b1;
        write_reg(CFG_VEL_MODE, 16'd0);
        write_reg(CFG_HOLD_TICKS, 16'd5);
        run_random(130);
        wait_drained();

        if (fault_count == 0 && levels_due.size() == 0)
            $display("midi_note_gate_trigger_tb: PASS");
        else
            $display("midi_note_gate_trigger_tb: FAIL");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("midi_note_gate_trigger_tb: FAIL");
        $finish;
    end

endmodule
